[sv/assert_macros.svh]
// assertion macros shared by the packer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define PPK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define PPK_NEVER(label, cond, msg) \
  `PPK_ASSERT(label, !(cond), msg)

`endif

[sv/ppk_pkg.sv]
// constants, types and register codes of the page packer
`timescale 1ns / 1ps

package ppk_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  // power of two: chunk number and position come from a shift and a mask
  localparam int CHUNK_BYTES = 16;
  localparam int BAND_ROWS   = 8;

  localparam int PIXEL_W      = 8;
  localparam int WIDTH_REG_W  = 8;
  localparam int HEIGHT_REG_W = 7;
  localparam int THRESH_W     = 8;
  localparam int PAGE_W       = 8;
  localparam int CHUNK_IDX_W  = 6;
  localparam int BYTE_POS_W   = 4;
  localparam int CFG_DATA_W   = 8;
  localparam int CFG_IDX_W    = 2;

  localparam int WIDTH_RESET  = 128;
  localparam int HEIGHT_RESET = 64;
  localparam int THRESH_RESET = 126;

  localparam int BAND_LOG  = $clog2(BAND_ROWS);
  localparam int CHUNK_LOG = $clog2(CHUNK_BYTES);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int WEFF_W    = $clog2(MAX_WIDTH + 1);
  localparam int HEFF_W    = $clog2(MAX_HEIGHT + 1);
  localparam int BANDS_W   = $clog2(MAX_HEIGHT / BAND_ROWS + 1);
  localparam int TOT_W     = WEFF_W + BANDS_W;
  localparam int BYTE_W    = $clog2(MAX_WIDTH * (MAX_HEIGHT / BAND_ROWS));
  localparam int COLBITS_W = BAND_ROWS - 1;

  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [COL_W-1:0]       col_t;
  typedef logic [ROW_W-1:0]       row_t;
  typedef logic [WEFF_W-1:0]      weff_t;
  typedef logic [HEFF_W-1:0]      heff_t;
  typedef logic [BANDS_W-1:0]     bands_t;
  typedef logic [TOT_W-1:0]       tot_t;
  typedef logic [BYTE_W-1:0]      byte_cnt_t;
  typedef logic [BAND_LOG-1:0]    sub_t;
  typedef logic [COLBITS_W-1:0]   colbits_t;
  typedef logic [CHUNK_IDX_W-1:0] chunk_idx_t;
  typedef logic [BYTE_POS_W-1:0]  byte_pos_t;
  typedef logic [FIFO_PTR_W-1:0]  fifo_ptr_t;
  typedef logic [FIFO_CNT_W-1:0]  fifo_cnt_t;

  localparam sub_t      SUB_FIRST = sub_t'(0);
  localparam sub_t      SUB_LAST  = sub_t'(BAND_ROWS - 1);
  localparam fifo_cnt_t FIFO_FULL = fifo_cnt_t'(FIFO_DEPTH);
  localparam fifo_ptr_t FIFO_LAST = fifo_ptr_t'(FIFO_DEPTH - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_PIXEL_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  image_width;
    logic [HEIGHT_REG_W-1:0] image_height;
    logic [THRESH_W-1:0]     pixel_threshold;
  } cfg_t;

  // one pixel after decode, handed from the sequencer to the column update
  typedef struct packed {
    col_t       col;
    sub_t       sub;
    logic       lit;
    logic       in_band;
    logic       emit;
    logic       done;
    chunk_idx_t chunk_index;
    byte_pos_t  byte_position;
  } item_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_byte;
    chunk_idx_t        chunk_index;
    byte_pos_t         byte_position;
    logic              image_done;
  } page_t;

endpackage

[sv/ppk_if.sv]
// valid/ready channel interfaces for pixels, page bytes and register writes
`timescale 1ns / 1ps

interface ppk_pix_if;
  logic                          valid;
  logic                          ready;
  logic [ppk_pkg::PIXEL_W-1:0]   pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface ppk_page_if;
  logic                            valid;
  logic                            ready;
  logic [ppk_pkg::PAGE_W-1:0]      page_byte;
  logic [ppk_pkg::CHUNK_IDX_W-1:0] chunk_index;
  logic [ppk_pkg::BYTE_POS_W-1:0]  byte_position;
  logic                            image_done;
  modport source (output valid, output page_byte, output chunk_index,
                  output byte_position, output image_done, input ready);
  modport sink   (input valid, input page_byte, input chunk_index,
                  input byte_position, input image_done, output ready);
endinterface

interface ppk_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ppk_pkg::CFG_IDX_W-1:0]  index;
  logic [ppk_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/ppk_ram.sv]
// generic single-clock ram, one write port and one registered read port
`timescale 1ns / 1ps

module ppk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/ppk_seq.sv]
// raster position counters, band decode and chunk numbering per pixel
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppk_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [ppk_pkg::PIXEL_W-1:0] pixel_value,
  input  ppk_pkg::cfg_t               cfg,
  output ppk_pkg::item_t              item
);

  ppk_pkg::col_t      col_r, col_nxt;
  ppk_pkg::row_t      row_r, row_nxt;
  ppk_pkg::byte_cnt_t byte_cnt_r, byte_cnt_nxt;

  ppk_pkg::weff_t w_eff;
  ppk_pkg::heff_t h_eff;
  ppk_pkg::heff_t band_rows;
  ppk_pkg::bands_t bands;
  ppk_pkg::tot_t  total;
  ppk_pkg::tot_t  emit_limit;
  ppk_pkg::tot_t  byte_ext;
  logic           col_wrap;
  logic           row_wrap;
  logic           in_band;
  ppk_pkg::sub_t  sub;

  // effective size: zero taken as one, larger values clamped to the store
  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = ppk_pkg::weff_t'(1);
    end else if (int'(cfg.image_width) > ppk_pkg::MAX_WIDTH) begin
      w_eff = ppk_pkg::weff_t'(ppk_pkg::MAX_WIDTH);
    end else begin
      w_eff = ppk_pkg::weff_t'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h_eff = ppk_pkg::heff_t'(1);
    end else if (int'(cfg.image_height) > ppk_pkg::MAX_HEIGHT) begin
      h_eff = ppk_pkg::heff_t'(ppk_pkg::MAX_HEIGHT);
    end else begin
      h_eff = ppk_pkg::heff_t'(cfg.image_height);
    end
  end

  assign bands      = ppk_pkg::bands_t'(h_eff >> ppk_pkg::BAND_LOG);
  assign band_rows  = h_eff & ~ppk_pkg::heff_t'(ppk_pkg::BAND_ROWS - 1);
  assign total      = ppk_pkg::tot_t'(w_eff) * ppk_pkg::tot_t'(bands);
  // bytes past the last whole chunk are never sent
  assign emit_limit = (total >> ppk_pkg::CHUNK_LOG) << ppk_pkg::CHUNK_LOG;
  assign byte_ext   = ppk_pkg::tot_t'(byte_cnt_r);

  assign col_wrap = (ppk_pkg::weff_t'(col_r) + ppk_pkg::weff_t'(1)) >= w_eff;
  assign row_wrap = (ppk_pkg::heff_t'(row_r) + ppk_pkg::heff_t'(1)) >= h_eff;
  assign in_band  = ppk_pkg::heff_t'(row_r) < band_rows;
  assign sub      = row_r[ppk_pkg::BAND_LOG-1:0];

  always_comb begin
    item.col           = col_r;
    item.sub           = sub;
    item.lit           = pixel_value > cfg.pixel_threshold;
    item.in_band       = in_band;
    item.emit          = in_band && (sub == ppk_pkg::SUB_LAST) && (byte_ext < emit_limit);
    item.done          = (byte_ext + ppk_pkg::tot_t'(1)) == emit_limit;
    item.chunk_index   = ppk_pkg::chunk_idx_t'(byte_cnt_r >> ppk_pkg::CHUNK_LOG);
    item.byte_position = ppk_pkg::byte_pos_t'(
                           byte_cnt_r & ppk_pkg::byte_cnt_t'(ppk_pkg::CHUNK_BYTES - 1));
  end

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    byte_cnt_nxt = byte_cnt_r;
    if (accept) begin
      if (in_band && (sub == ppk_pkg::SUB_LAST)) begin
        byte_cnt_nxt = byte_cnt_r + ppk_pkg::byte_cnt_t'(1);
      end
      if (col_wrap) begin
        col_nxt = '0;
        if (row_wrap) begin
          row_nxt      = '0;
          byte_cnt_nxt = '0;
        end else begin
          row_nxt = row_r + ppk_pkg::row_t'(1);
        end
      end else begin
        col_nxt = col_r + ppk_pkg::col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      byte_cnt_r <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

  `PPK_ASSERT(a_image_restart, (accept && col_wrap && row_wrap) |=> (col_r == '0 && row_r == '0 && byte_cnt_r == '0), "counters did not restart after the last pixel")

endmodule

[sv/ppk_pack.sv]
// column store read-modify-write with forwarding of the previous write
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppk_pack (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  ppk_pkg::item_t item,
  output logic           s1_valid,
  output logic           push,
  output ppk_pkg::page_t page
);

  logic              s1_valid_r;
  ppk_pkg::item_t    s1_item_r;
  ppk_pkg::colbits_t rdata;
  ppk_pkg::colbits_t old_bits;
  ppk_pkg::colbits_t wdata;
  logic              we;

  logic              last_we_r;
  ppk_pkg::col_t     last_waddr_r;
  ppk_pkg::colbits_t last_wdata_r;
  logic              fwd_hit;

  ppk_ram #(
    .WIDTH (ppk_pkg::COLBITS_W),
    .DEPTH (ppk_pkg::MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_item_r.col),
    .wdata (wdata),
    .re    (accept),
    .raddr (item.col),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      last_we_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      last_we_r  <= we;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= item;
    end
    if (we) begin
      last_waddr_r <= s1_item_r.col;
      last_wdata_r <= wdata;
    end
  end

  // a read issued in the same cycle as a write to its column saw stale data
  assign fwd_hit  = last_we_r && (last_waddr_r == s1_item_r.col);
  assign old_bits = fwd_hit ? last_wdata_r : rdata;

  assign we = s1_valid_r && s1_item_r.in_band && (s1_item_r.sub != ppk_pkg::SUB_LAST);

  always_comb begin
    if (s1_item_r.sub == ppk_pkg::SUB_FIRST) begin
      wdata = ppk_pkg::colbits_t'(s1_item_r.lit);
    end else begin
      wdata = old_bits | (ppk_pkg::colbits_t'(s1_item_r.lit) << s1_item_r.sub);
    end
  end

  assign s1_valid = s1_valid_r;
  assign push     = s1_valid_r && s1_item_r.emit;

  always_comb begin
    page.page_byte     = {s1_item_r.lit, old_bits};
    page.chunk_index   = s1_item_r.chunk_index;
    page.byte_position = s1_item_r.byte_position;
    page.image_done    = s1_item_r.done;
  end

  `PPK_ASSERT(a_push_on_band_end, push |-> (s1_item_r.in_band && s1_item_r.sub == ppk_pkg::SUB_LAST), "page byte sent outside the last row of a band")

endmodule

[sv/ppk_fifo.sv]
// three-entry result queue in front of the output channel
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppk_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ppk_pkg::page_t      push_data,
  input  logic                pop,
  output logic                head_valid,
  output ppk_pkg::page_t      head,
  output ppk_pkg::fifo_cnt_t  count
);

  ppk_pkg::page_t     slot_r [ppk_pkg::FIFO_DEPTH];
  ppk_pkg::fifo_ptr_t wr_ptr_r, wr_ptr_nxt;
  ppk_pkg::fifo_ptr_t rd_ptr_r, rd_ptr_nxt;
  ppk_pkg::fifo_cnt_t count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ppk_pkg::FIFO_LAST) ? '0 : wr_ptr_r + ppk_pkg::fifo_ptr_t'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ppk_pkg::FIFO_LAST) ? '0 : rd_ptr_r + ppk_pkg::fifo_ptr_t'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + ppk_pkg::fifo_cnt_t'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - ppk_pkg::fifo_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = count_r != '0;
  assign head       = slot_r[rd_ptr_r];
  assign count      = count_r;

  `PPK_NEVER(a_no_overflow, push && !pop && count_r == ppk_pkg::FIFO_FULL, "result queue overflow")
  `PPK_NEVER(a_no_underflow, pop && count_r == '0, "result queue popped while empty")

endmodule

[sv/mono_pixel_to_page_packer.sv]
// top level of the monochrome pixel to page byte packer
`timescale 1ns / 1ps

// Usage:
// in_pix carries one 8-bit grey pixel per beat in raster order. A pixel lights
// when it is above pixel_threshold. Each band of 8 rows turns into one byte per
// column (top row in bit 0), sent on out_page as the band's last row passes
// that column, with its chunk number, its position in the chunk and a flag on
// the last byte of the image. Rows below the last whole band and bytes after
// the last whole 16-byte chunk are dropped.
// cfg_wr writes image_width (0), image_height (1) and pixel_threshold (2); it is
// always ready and is to be written only while no pixel is in flight.
// Timing: one pixel per cycle while in_pix.ready is high. A byte is registered
// in the column stage, then in the result queue, before it shows on out_page.
// The rate is set by the column store: one read and one write of a 128 x 7 ram
// per pixel, one pixel's write forwarded to the next pixel's read on a column hit.
// Reset: counters go to the start of an image and registers to 128 x 64 with a
// threshold of 126; the column store needs no clearing pass.
// Stall: a three-entry queue holds finished bytes; in_pix.ready drops only when
// the queue and the pixel in flight could fill it.

module mono_pixel_to_page_packer (
  input  logic clk,
  input  logic rst_n,
  ppk_pix_if.sink    in_pix,
  ppk_page_if.source out_page,
  ppk_cfg_if.sink    cfg_wr
);

  logic [ppk_pkg::WIDTH_REG_W-1:0]  width_r;
  logic [ppk_pkg::HEIGHT_REG_W-1:0] height_r;
  logic [ppk_pkg::THRESH_W-1:0]     thresh_r;
  ppk_pkg::cfg_t                    cfg;

  logic               in_accept;
  ppk_pkg::item_t     item;
  logic               s1_valid;
  logic               push;
  ppk_pkg::page_t     page;
  logic               pop;
  logic               head_valid;
  ppk_pkg::page_t     head;
  ppk_pkg::fifo_cnt_t fifo_count;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ppk_pkg::WIDTH_REG_W'(ppk_pkg::WIDTH_RESET);
      height_r <= ppk_pkg::HEIGHT_REG_W'(ppk_pkg::HEIGHT_RESET);
      thresh_r <= ppk_pkg::THRESH_W'(ppk_pkg::THRESH_RESET);
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        ppk_pkg::CFG_IMAGE_WIDTH: begin
          width_r <= cfg_wr.data[ppk_pkg::WIDTH_REG_W-1:0];
        end
        ppk_pkg::CFG_IMAGE_HEIGHT: begin
          height_r <= cfg_wr.data[ppk_pkg::HEIGHT_REG_W-1:0];
        end
        ppk_pkg::CFG_PIXEL_THRESHOLD: begin
          thresh_r <= cfg_wr.data[ppk_pkg::THRESH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.image_width     = width_r;
    cfg.image_height    = height_r;
    cfg.pixel_threshold = thresh_r;
  end

  // room for the pixel in flight plus a new one, from registers only
  assign in_pix.ready = ({1'b0, fifo_count} + {{ppk_pkg::FIFO_CNT_W{1'b0}}, s1_valid})
                        < (ppk_pkg::FIFO_CNT_W + 1)'(ppk_pkg::FIFO_DEPTH);
  assign in_accept = in_pix.valid && in_pix.ready;

  ppk_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .pixel_value (in_pix.pixel_value),
    .cfg         (cfg),
    .item        (item)
  );

  ppk_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .item     (item),
    .s1_valid (s1_valid),
    .push     (push),
    .page     (page)
  );

  assign pop = head_valid && out_page.ready;

  ppk_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (page),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (fifo_count)
  );

  assign out_page.valid         = head_valid;
  assign out_page.page_byte     = head.page_byte;
  assign out_page.chunk_index   = head.chunk_index;
  assign out_page.byte_position = head.byte_position;
  assign out_page.image_done    = head.image_done;

endmodule
